@@ src/rgbhsv_pkg.sv @@
// shared widths, defaults and types of the rgb to hsv converter
`default_nettype none

package rgbhsv_pkg;

	// field widths
	localparam int RGB_W = 8;
	localparam int HUE_W = 15;
	localparam int SAT_W = 16;

	// divider cells work on a doubled 8-bit divisor
	localparam int DIV_W = RGB_W + 1;

	// default fraction bits of hue and saturation
	localparam int HUE_FRAC_BITS_DEF = 6;
	localparam int SAT_FRAC_BITS_DEF = 15;

	// one full turn in degrees
	localparam int HUE_TURN = 360;

	// divisors handed down the cell row
	typedef struct packed {
		logic [DIV_W-1:0] hdiv;
		logic [DIV_W-1:0] sdiv;
	} rgbhsv_div_t;

	// per-pixel data that rides along the row untouched
	typedef struct packed {
		logic             hue_zero;
		logic             sat_zero;
		logic [RGB_W-1:0] value;
	} rgbhsv_side_t;

endpackage

`default_nettype wire

@@ src/rgbhsv_front.sv @@
// front end: max, min, sector, and the dividend and divisor loads for the cell row
`default_nettype none

module rgbhsv_front import rgbhsv_pkg::*; #(
	parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
	parameter int SAT_FRAC_BITS = SAT_FRAC_BITS_DEF,
	localparam int HQW = HUE_FRAC_BITS + 9,
	localparam int SQW = SAT_FRAC_BITS + 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               valid_i,
	input  wire logic [RGB_W-1:0]   red,
	input  wire logic [RGB_W-1:0]   green,
	input  wire logic [RGB_W-1:0]   blue,
	output logic                    valid_o,
	output logic [DIV_W-1:0]        hrem_o,
	output logic [HQW-1:0]          hq_o,
	output logic [DIV_W-1:0]        srem_o,
	output logic [SQW-1:0]          sq_o,
	output rgbhsv_div_t             div_o,
	output rgbhsv_side_t            side_o
);

	// hue numerator is below 360 * 255, 17 bits
	localparam int NUM_W = 17;
	localparam int HNW   = NUM_W + HUE_FRAC_BITS + 2;
	localparam int SNW   = SAT_FRAC_BITS + 9;

	localparam logic [NUM_W-1:0] BASE_GREEN = NUM_W'(120);
	localparam logic [NUM_W-1:0] BASE_BLUE  = NUM_W'(240);
	localparam logic [NUM_W-1:0] BASE_WRAP  = NUM_W'(HUE_TURN);

	typedef enum logic [1:0] {
		SEC_RED_POS,
		SEC_RED_NEG,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// stage 1 comb
	logic                    red_max;
	logic                    grn_max;
	logic [RGB_W-1:0]        mx;
	logic [RGB_W-1:0]        mn;
	sector_t                 sec;
	logic signed [RGB_W:0]   diff;

	// stage 1 registers
	logic                    valid_s1;
	logic [RGB_W-1:0]        mx_s1;
	logic [RGB_W-1:0]        delta_s1;
	sector_t                 sec_s1;
	logic signed [RGB_W:0]   diff_s1;

	// stage 2 comb
	logic [NUM_W-1:0]        base_prod;
	logic signed [NUM_W+1:0] n_wide;
	logic [NUM_W-1:0]        hnum_base;
	logic [HNW-1:0]          hnum;
	logic [SNW-1:0]          snum;

	always_comb begin
		red_max = (red >= green) && (red >= blue);
		grn_max = !red_max && (green >= blue);
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		if (red_max) begin
			sec  = (green >= blue) ? SEC_RED_POS : SEC_RED_NEG;
			diff = signed'({1'b0, green}) - signed'({1'b0, blue});
		end else if (grn_max) begin
			sec  = SEC_GREEN;
			diff = signed'({1'b0, blue}) - signed'({1'b0, red});
		end else begin
			sec  = SEC_BLUE;
			diff = signed'({1'b0, red}) - signed'({1'b0, green});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_o  <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
			valid_o  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1    <= mx;
			delta_s1 <= mx - mn;
			sec_s1   <= sec;
			diff_s1  <= diff;
		end
	end

	// base * delta + 60 * signed difference, never negative
	always_comb begin
		case (sec_s1)
			SEC_RED_POS: base_prod = '0;
			SEC_RED_NEG: base_prod = NUM_W'(BASE_WRAP * NUM_W'(delta_s1));
			SEC_GREEN:   base_prod = NUM_W'(BASE_GREEN * NUM_W'(delta_s1));
			SEC_BLUE:    base_prod = NUM_W'(BASE_BLUE * NUM_W'(delta_s1));
			default:     base_prod = '0;
		endcase
		n_wide    = signed'({2'b00, base_prod}) + (NUM_W+2)'(diff_s1) * (NUM_W+2)'(60);
		hnum_base = n_wide[NUM_W-1:0];
		// rounded half up: (2 * n * 2^h + delta) / (2 * delta)
		hnum = (HNW'(hnum_base) << (HUE_FRAC_BITS + 1)) + HNW'(delta_s1);
		// (2 * delta * 2^s + max) / (2 * max)
		snum = (SNW'(delta_s1) << (SAT_FRAC_BITS + 1)) + SNW'(mx_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hrem_o          <= hnum[HQW +: DIV_W];
			hq_o            <= hnum[HQW-1:0];
			srem_o          <= {1'b0, snum[SNW-1:SQW]};
			sq_o            <= snum[SQW-1:0];
			div_o.hdiv      <= {delta_s1, 1'b0};
			div_o.sdiv      <= {mx_s1, 1'b0};
			side_o.hue_zero <= (delta_s1 == '0);
			side_o.sat_zero <= (mx_s1 == '0);
			side_o.value    <= mx_s1;
		end
	end

endmodule

`default_nettype wire

@@ src/rgbhsv_cell.sv @@
// one divider cell: a restoring step for hue and saturation, one bit each until done
`default_nettype none

module rgbhsv_cell import rgbhsv_pkg::*; #(
	parameter int HQW  = HUE_FRAC_BITS_DEF + 9,
	parameter int SQW  = SAT_FRAC_BITS_DEF + 1,
	parameter int STEP = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              valid_i,
	input  wire logic [DIV_W-1:0]  hrem_i,
	input  wire logic [HQW-1:0]    hq_i,
	input  wire logic [DIV_W-1:0]  srem_i,
	input  wire logic [SQW-1:0]    sq_i,
	input  wire rgbhsv_div_t       div_i,
	input  wire rgbhsv_side_t      side_i,
	output logic                   valid_o,
	output logic [DIV_W-1:0]       hrem_o,
	output logic [HQW-1:0]         hq_o,
	output logic [DIV_W-1:0]       srem_o,
	output logic [SQW-1:0]         sq_o,
	output rgbhsv_div_t            div_o,
	output rgbhsv_side_t           side_o
);

	logic [DIV_W:0]   ht;
	logic [DIV_W:0]   st;
	logic             hge;
	logic             sge;
	logic [DIV_W-1:0] hrem_n;
	logic [HQW-1:0]   hq_n;
	logic [DIV_W-1:0] srem_n;
	logic [SQW-1:0]   sq_n;

	always_comb begin
		ht  = {hrem_i, hq_i[HQW-1]};
		st  = {srem_i, sq_i[SQW-1]};
		hge = ht >= {1'b0, div_i.hdiv};
		sge = st >= {1'b0, div_i.sdiv};
		// the shorter quotient is done early and just rides along
		if (STEP < HQW) begin
			hrem_n = hge ? DIV_W'(ht - {1'b0, div_i.hdiv}) : ht[DIV_W-1:0];
			hq_n   = {hq_i[HQW-2:0], hge};
		end else begin
			hrem_n = hrem_i;
			hq_n   = hq_i;
		end
		if (STEP < SQW) begin
			srem_n = sge ? DIV_W'(st - {1'b0, div_i.sdiv}) : st[DIV_W-1:0];
			sq_n   = {sq_i[SQW-2:0], sge};
		end else begin
			srem_n = srem_i;
			sq_n   = sq_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hrem_o <= hrem_n;
			hq_o   <= hq_n;
			srem_o <= srem_n;
			sq_o   <= sq_n;
			div_o  <= div_i;
			side_o <= side_i;
		end
	end

endmodule

`default_nettype wire

@@ src/rgb_to_hsv_converter.sv @@
// top level: rgb pixel in, hexcone hsv out, front end plus a row of divider cells
`default_nettype none

// channel   signals                              direction
// pix       pix_valid, pix_stall, red/green/blue  in  (pix_stall driven here)
// hsv       hsv_valid, hsv_stall, hue/sat/value   out (hsv_stall driven by sink)
//
// one pixel per cycle sustained while pix_stall is low; the row of divider
// cells each retire one quotient bit of hue and of saturation until the
// shorter quotient is complete, after which only the longer one advances.
// reset clears only valid bits; no pixel state is kept.
// a stalled output parks one more result in a skid register, then pix_stall rises.

module rgb_to_hsv_converter import rgbhsv_pkg::*; #(
	parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
	parameter int SAT_FRAC_BITS = SAT_FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             pix_valid,
	output logic                  pix_stall,
	input  wire logic [RGB_W-1:0] red,
	input  wire logic [RGB_W-1:0] green,
	input  wire logic [RGB_W-1:0] blue,
	output logic                  hsv_valid,
	input  wire logic             hsv_stall,
	output logic [HUE_W-1:0]      hue,
	output logic [SAT_W-1:0]      saturation,
	output logic [RGB_W-1:0]      value
);

	// quotient widths: hue stays below 512 * 2^h, saturation reaches 2^s
	localparam int HQW   = HUE_FRAC_BITS + 9;
	localparam int SQW   = SAT_FRAC_BITS + 1;
	localparam int CELLS = (HQW > SQW) ? HQW : SQW;

	localparam logic [HQW-1:0] HUE_FULL = HQW'(HUE_TURN) << HUE_FRAC_BITS;

	// cell row taps, index 0 is the front end output
	logic               valid_c [0:CELLS];
	logic [DIV_W-1:0]   hrem_c  [0:CELLS];
	logic [HQW-1:0]     hq_c    [0:CELLS];
	logic [DIV_W-1:0]   srem_c  [0:CELLS];
	logic [SQW-1:0]     sq_c    [0:CELLS];
	rgbhsv_div_t        div_c   [0:CELLS];
	rgbhsv_side_t       side_c  [0:CELLS];

	// whole row moves together while the skid register is empty
	logic               pipe_en;

	// output and skid registers
	logic               out_valid_q;
	logic [HQW-1:0]     hue_out_q;
	logic [SQW-1:0]     sat_out_q;
	logic [RGB_W-1:0]   val_out_q;
	logic               skid_valid_q;
	logic [HQW-1:0]     hue_skid_q;
	logic [SQW-1:0]     sat_skid_q;
	logic [RGB_W-1:0]   val_skid_q;

	// finished result leaving the last cell
	logic [HQW-1:0]     hue_n;
	logic [SQW-1:0]     sat_n;
	logic               take;
	logic               arrive;
	logic               load_out;

	assign pipe_en   = !skid_valid_q;
	assign pix_stall = skid_valid_q;

	rgbhsv_front #(
		.HUE_FRAC_BITS (HUE_FRAC_BITS),
		.SAT_FRAC_BITS (SAT_FRAC_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (pipe_en),
		.valid_i (pix_valid),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.valid_o (valid_c[0]),
		.hrem_o  (hrem_c[0]),
		.hq_o    (hq_c[0]),
		.srem_o  (srem_c[0]),
		.sq_o    (sq_c[0]),
		.div_o   (div_c[0]),
		.side_o  (side_c[0])
	);

	// one cell per bit of the longer quotient, each hands its partial remainder to the next
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		rgbhsv_cell #(
			.HQW  (HQW),
			.SQW  (SQW),
			.STEP (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (pipe_en),
			.valid_i (valid_c[i]),
			.hrem_i  (hrem_c[i]),
			.hq_i    (hq_c[i]),
			.srem_i  (srem_c[i]),
			.sq_i    (sq_c[i]),
			.div_i   (div_c[i]),
			.side_i  (side_c[i]),
			.valid_o (valid_c[i+1]),
			.hrem_o  (hrem_c[i+1]),
			.hq_o    (hq_c[i+1]),
			.srem_o  (srem_c[i+1]),
			.sq_o    (sq_c[i+1]),
			.div_o   (div_c[i+1]),
			.side_o  (side_c[i+1])
		);
	end

	// gray pixel forces hue to zero, black forces saturation to zero,
	// and a hue that rounds up to a full turn wraps to zero
	always_comb begin
		if (side_c[CELLS].hue_zero) begin
			hue_n = '0;
		end else if (hq_c[CELLS] >= HUE_FULL) begin
			hue_n = hq_c[CELLS] - HUE_FULL;
		end else begin
			hue_n = hq_c[CELLS];
		end
		sat_n = side_c[CELLS].sat_zero ? '0 : sq_c[CELLS];
	end

	assign take     = out_valid_q && !hsv_stall;
	assign arrive   = pipe_en && valid_c[CELLS];
	assign load_out = !out_valid_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= arrive;
			end
		end else if (arrive) begin
			// output held by the sink, park this transfer
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (skid_valid_q) begin
				hue_out_q <= hue_skid_q;
				sat_out_q <= sat_skid_q;
				val_out_q <= val_skid_q;
			end else begin
				hue_out_q <= hue_n;
				sat_out_q <= sat_n;
				val_out_q <= side_c[CELLS].value;
			end
		end else if (arrive) begin
			hue_skid_q <= hue_n;
			sat_skid_q <= sat_n;
			val_skid_q <= side_c[CELLS].value;
		end
	end

	assign hsv_valid  = out_valid_q;
	assign hue        = HUE_W'(hue_out_q);
	assign saturation = SAT_W'(sat_out_q);
	assign value      = val_out_q;

	// skid register only fills behind a held output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full while output register empty");

	// black pixel gives zero hue and zero saturation
	a_black_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(hsv_valid && (value == '0)) |-> ((hue == '0) && (saturation == '0)))
		else $error("black pixel with nonzero hue or saturation");

	// hue always wrapped below a full turn
	a_hue_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> (hue_out_q < HUE_FULL))
		else $error("hue not wrapped below a full turn");

endmodule

`default_nettype wire
